@@ src/scr_pkg.sv @@
package scr_pkg;

   localparam int SRC_BITS = 15;
   localparam int QUO_BITS = 15;
   localparam int OUT_SRC_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CLIP_LEFT   = 2'd0,
      CSR_CLIP_TOP    = 2'd1,
      CSR_CLIP_SPAN_X = 2'd2,
      CSR_CLIP_SPAN_Y = 2'd3
   } csr_index_type;

endpackage

@@ src/scr_div.sv @@
module scr_div #(
   parameter int DEN_BITS = 15
) (
   input  logic                                  clock,
   input  logic                                  enable,
   input  logic [DEN_BITS+scr_pkg::QUO_BITS-1:0] num,
   input  logic [DEN_BITS-1:0]                   den,
   output logic [scr_pkg::QUO_BITS-1:0]          quo
);

   localparam int QB = scr_pkg::QUO_BITS;

   logic [DEN_BITS-1:0] rem_ff [QB];
   logic [QB-1:0]       low_ff [QB];
   logic [QB-1:0]       quo_ff [QB];
   logic [DEN_BITS-1:0] den_ff [QB];

   genvar k;
   generate
      for (k = 0; k < QB; k++) begin : g_step
         logic [DEN_BITS-1:0] rem_prev;
         logic [QB-1:0]       low_prev;
         logic [QB-1:0]       quo_prev;
         logic [DEN_BITS-1:0] den_prev;
         logic [DEN_BITS:0]   trial;
         logic                ge;
         logic [DEN_BITS:0]   diff;
         logic [DEN_BITS-1:0] rem_in;

         if (k == 0) begin : g_first
            assign rem_prev = num[DEN_BITS+QB-1:QB];
            assign low_prev = num[QB-1:0];
            assign quo_prev = '0;
            assign den_prev = den;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign low_prev = low_ff[k-1];
            assign quo_prev = quo_ff[k-1];
            assign den_prev = den_ff[k-1];
         end

         assign trial  = {rem_prev, low_prev[QB-1-k]};
         assign ge     = trial >= {1'b0, den_prev};
         assign diff   = trial - {1'b0, den_prev};
         assign rem_in = ge ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k] <= rem_in;
               low_ff[k] <= low_prev;
               quo_ff[k] <= {quo_prev[QB-2:0], ge};
               den_ff[k] <= den_prev;
            end
         end
      end
   endgenerate

   assign quo = quo_ff[QB-1];

endmodule

@@ src/sprite_clip_source_rescale.sv @@
// Sprite clip and source rescale. Takes one draw word per cycle unless
// stalled and returns one result word per draw, passing through one clip
// stage, one multiply stage, one stage per quotient bit in each of four
// pipelined dividers, and an output register. The whole pipeline holds
// while a result waits under rsp_stall. Write the clip registers only
// while the block is idle.
module sprite_clip_source_rescale #(
   parameter int COORD_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [scr_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [((COORD_BITS > scr_pkg::SRC_BITS) ? COORD_BITS : scr_pkg::SRC_BITS)-1:0]
                                                 csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_dst_x,
   input  logic signed [COORD_BITS-1:0]          req_dst_y,
   input  logic signed [COORD_BITS-1:0]          req_dst_w,
   input  logic signed [COORD_BITS-1:0]          req_dst_h,
   input  logic [scr_pkg::SRC_BITS-1:0]          req_src_x,
   input  logic [scr_pkg::SRC_BITS-1:0]          req_src_y,
   input  logic [scr_pkg::SRC_BITS-1:0]          req_src_w,
   input  logic [scr_pkg::SRC_BITS-1:0]          req_src_h,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [COORD_BITS-1:0]          rsp_out_dst_x,
   output logic signed [COORD_BITS-1:0]          rsp_out_dst_y,
   output logic [COORD_BITS-1:0]                 rsp_out_dst_w,
   output logic [COORD_BITS-1:0]                 rsp_out_dst_h,
   output logic [scr_pkg::OUT_SRC_BITS-1:0]      rsp_out_src_x,
   output logic [scr_pkg::OUT_SRC_BITS-1:0]      rsp_out_src_y,
   output logic [scr_pkg::OUT_SRC_BITS-1:0]      rsp_out_src_w,
   output logic [scr_pkg::OUT_SRC_BITS-1:0]      rsp_out_src_h
);

   localparam int C  = COORD_BITS;
   localparam int SB = scr_pkg::SRC_BITS;
   localparam int QB = scr_pkg::QUO_BITS;
   localparam int OB = scr_pkg::OUT_SRC_BITS;
   localparam int SW = ((C > 16) ? C : 16) + 2;
   localparam int DB = C - 1;
   localparam int NW = DB + QB;

   typedef struct packed {
      logic          fallback;
      logic [C-1:0]  cx;
      logic [C-1:0]  cy;
      logic [C-1:0]  left;
      logic [C-1:0]  top;
      logic [C-1:0]  ow;
      logic [C-1:0]  oh;
      logic [SB-1:0] sx;
      logic [SB-1:0] sy;
      logic [SB-1:0] sw;
      logic [SB-1:0] sh;
   } side_type;

   logic [C-1:0]  clip_left_ff, clip_top_ff;
   logic [SB-1:0] clip_span_x_ff, clip_span_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_span_x_ff <= '0;
         clip_span_y_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (scr_pkg::csr_index_type'(csr_index))
            scr_pkg::CSR_CLIP_LEFT:   clip_left_ff   <= csr_wdata[C-1:0];
            scr_pkg::CSR_CLIP_TOP:    clip_top_ff    <= csr_wdata[C-1:0];
            scr_pkg::CSR_CLIP_SPAN_X: clip_span_x_ff <= csr_wdata[SB-1:0];
            scr_pkg::CSR_CLIP_SPAN_Y: clip_span_y_ff <= csr_wdata[SB-1:0];
            default: ;
         endcase
      end
   end

   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // clip stage
   logic signed [SW-1:0] dx, dy, dw, dh, cx, cy, cw, ch;
   logic signed [SW-1:0] left, top, right, bottom, dend_x, dend_y, cend_x, cend_y;
   logic signed [SW-1:0] dl, dr, dt, dbt, ow, oh;
   logic fallback;

   assign dx = {{(SW-C){req_dst_x[C-1]}}, req_dst_x};
   assign dy = {{(SW-C){req_dst_y[C-1]}}, req_dst_y};
   assign dw = {{(SW-C){req_dst_w[C-1]}}, req_dst_w};
   assign dh = {{(SW-C){req_dst_h[C-1]}}, req_dst_h};
   assign cx = {{(SW-C){clip_left_ff[C-1]}}, clip_left_ff};
   assign cy = {{(SW-C){clip_top_ff[C-1]}}, clip_top_ff};
   assign cw = {{(SW-SB){1'b0}}, clip_span_x_ff};
   assign ch = {{(SW-SB){1'b0}}, clip_span_y_ff};

   assign dend_x = dx + dw;
   assign dend_y = dy + dh;
   assign cend_x = cx + cw;
   assign cend_y = cy + ch;
   assign left   = (dx > cx) ? dx : cx;
   assign top    = (dy > cy) ? dy : cy;
   assign right  = (dend_x < cend_x) ? dend_x : cend_x;
   assign bottom = (dend_y < cend_y) ? dend_y : cend_y;
   assign dl  = left - dx;
   assign dr  = right - dx;
   assign dt  = top - dy;
   assign dbt = bottom - dy;
   assign ow  = right - left;
   assign oh  = bottom - top;
   assign fallback = (dw <= 0) || (dh <= 0) || (right <= left) || (bottom <= top);

   logic     v1_ff;
   side_type s1_ff;
   logic [DB-1:0] dl1_ff, dr1_ff, dt1_ff, db1_ff, dw1_ff, dh1_ff;
   side_type s1_in;

   always_comb begin
      s1_in.fallback = fallback;
      s1_in.cx   = clip_left_ff;
      s1_in.cy   = clip_top_ff;
      s1_in.left = left[C-1:0];
      s1_in.top  = top[C-1:0];
      s1_in.ow   = ow[C-1:0];
      s1_in.oh   = oh[C-1:0];
      s1_in.sx   = req_src_x;
      s1_in.sy   = req_src_y;
      s1_in.sw   = req_src_w;
      s1_in.sh   = req_src_h;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff  <= s1_in;
         dl1_ff <= dl[DB-1:0];
         dr1_ff <= dr[DB-1:0];
         dt1_ff <= dt[DB-1:0];
         db1_ff <= dbt[DB-1:0];
         dw1_ff <= dw[DB-1:0];
         dh1_ff <= dh[DB-1:0];
      end
   end

   // multiply stage
   logic     v2_ff;
   side_type s2_ff;
   logic [NW-1:0] pl2_ff, pr2_ff, pt2_ff, pb2_ff;
   logic [DB-1:0] dw2_ff, dh2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ff  <= s1_ff;
         pl2_ff <= NW'(dl1_ff) * NW'(s1_ff.sw);
         pr2_ff <= NW'(dr1_ff) * NW'(s1_ff.sw);
         pt2_ff <= NW'(dt1_ff) * NW'(s1_ff.sh);
         pb2_ff <= NW'(db1_ff) * NW'(s1_ff.sh);
         dw2_ff <= dw1_ff;
         dh2_ff <= dh1_ff;
      end
   end

   logic [QB-1:0] ql, qr, qt, qb;

   scr_div #(.DEN_BITS(DB)) u_div_l (
      .clock(clock), .enable(advance), .num(pl2_ff), .den(dw2_ff), .quo(ql));
   scr_div #(.DEN_BITS(DB)) u_div_r (
      .clock(clock), .enable(advance), .num(pr2_ff), .den(dw2_ff), .quo(qr));
   scr_div #(.DEN_BITS(DB)) u_div_t (
      .clock(clock), .enable(advance), .num(pt2_ff), .den(dh2_ff), .quo(qt));
   scr_div #(.DEN_BITS(DB)) u_div_b (
      .clock(clock), .enable(advance), .num(pb2_ff), .den(dh2_ff), .quo(qb));

   side_type side_ff [QB];
   logic [QB-1:0] vq_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= s2_ff;
         for (int i = 1; i < QB; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         vq_ff     <= '0;
         rsp_valid <= 1'b0;
      end else if (advance) begin
         v1_ff     <= req_valid;
         v2_ff     <= v1_ff;
         vq_ff     <= {vq_ff[QB-2:0], v2_ff};
         rsp_valid <= vq_ff[QB-1];
      end
   end

   // output stage
   side_type      so;
   logic [OB-1:0] src_l, src_r, src_t, src_b;

   assign so    = side_ff[QB-1];
   assign src_l = OB'(so.sx) + OB'(ql);
   assign src_r = OB'(so.sx) + OB'(qr);
   assign src_t = OB'(so.sy) + OB'(qt);
   assign src_b = OB'(so.sy) + OB'(qb);

   always_ff @(posedge clock) begin
      if (advance) begin
         if (so.fallback) begin
            rsp_out_dst_x <= so.cx;
            rsp_out_dst_y <= so.cy;
            rsp_out_dst_w <= C'(1);
            rsp_out_dst_h <= C'(1);
            rsp_out_src_x <= OB'(so.sx);
            rsp_out_src_y <= OB'(so.sy);
            rsp_out_src_w <= OB'(so.sw);
            rsp_out_src_h <= OB'(so.sh);
         end else begin
            rsp_out_dst_x <= so.left;
            rsp_out_dst_y <= so.top;
            rsp_out_dst_w <= so.ow;
            rsp_out_dst_h <= so.oh;
            rsp_out_src_x <= src_l;
            rsp_out_src_y <= src_t;
            rsp_out_src_w <= src_r - src_l;
            rsp_out_src_h <= src_b - src_t;
         end
      end
   end

endmodule

@@ src/scr_checker.sv @@
module scr_checker #(
   parameter int COORD_BITS = 16
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [COORD_BITS-1:0] rsp_out_dst_w,
   input logic [COORD_BITS-1:0] rsp_out_dst_h,
   input logic [scr_pkg::OUT_SRC_BITS-1:0] rsp_out_src_x
);

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a held result word");

   a_width_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_dst_w != 0) && (rsp_out_dst_h != 0))
      else $error("result word with empty destination");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_out_src_x))
      else $error("stalled result word changed");

endmodule

bind sprite_clip_source_rescale scr_checker #(.COORD_BITS(COORD_BITS)) u_scr_checker (
   .clock(clock),
   .reset(reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_out_dst_w(rsp_out_dst_w),
   .rsp_out_dst_h(rsp_out_dst_h),
   .rsp_out_src_x(rsp_out_src_x)
);

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = 16;
   localparam int LIMIT = 400000;

   typedef struct packed {
      logic signed [15:0] dx, dy, dw, dh;
      logic [14:0] sx, sy, sw, sh;
   } draw_type;

   typedef struct packed {
      logic [15:0] dx, dy, dw, dh, sx, sy, sw, sh;
   } blit_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [15:0] req_dst_x = 0, req_dst_y = 0, req_dst_w = 0, req_dst_h = 0;
   logic [14:0] req_src_x = 0, req_src_y = 0, req_src_w = 0, req_src_h = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [15:0] rsp_out_dst_x, rsp_out_dst_y;
   logic [15:0] rsp_out_dst_w, rsp_out_dst_h;
   logic [15:0] rsp_out_src_x, rsp_out_src_y, rsp_out_src_w, rsp_out_src_h;

   sprite_clip_source_rescale #(.COORD_BITS(CW)) u_top (.*);

   always #1 clock = ~clock;

   draw_type pending_draws[$];
   blit_type expected_blits[$];
   logic signed [15:0] clip_x0 = 0, clip_y0 = 0;
   logic [14:0] clip_wx = 0, clip_hy = 0;
   int send_idle = 0, recv_idle = 0;
   int errors = 0, cycles = 0, accepted = 0, received = 0, fallbacks = 0;

   function automatic blit_type clip_blit(draw_type d);
      blit_type r;
      longint l, t, rt, b, dx, dy, dw, dh, sx, sy, sw, sh;
      dx = longint'(d.dx);
      dy = longint'(d.dy);
      dw = longint'(d.dw);
      dh = longint'(d.dh);
      sx = longint'(d.sx);
      sy = longint'(d.sy);
      sw = longint'(d.sw);
      sh = longint'(d.sh);
      l = (dx > longint'(clip_x0)) ? dx : longint'(clip_x0);
      t = (dy > longint'(clip_y0)) ? dy : longint'(clip_y0);
      rt = ((dx + dw) < (longint'(clip_x0) + longint'(clip_wx))) ?
           dx + dw : longint'(clip_x0) + longint'(clip_wx);
      b = ((dy + dh) < (longint'(clip_y0) + longint'(clip_hy))) ?
          dy + dh : longint'(clip_y0) + longint'(clip_hy);
      if (dw <= 0 || dh <= 0 || rt <= l || b <= t) begin
         r = '{clip_x0, clip_y0, 16'd1, 16'd1,
               {1'b0, d.sx}, {1'b0, d.sy}, {1'b0, d.sw}, {1'b0, d.sh}};
      end else begin
         longint sl, st, sr, sb;
         sl = sx + ((l - dx) * sw) / dw;
         st = sy + ((t - dy) * sh) / dh;
         sr = sx + ((rt - dx) * sw) / dw;
         sb = sy + ((b - dy) * sh) / dh;
         r = '{l[15:0], t[15:0], 16'(rt - l), 16'(b - t),
               sl[15:0], st[15:0], 16'(sr - sl), 16'(sb - st)};
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            draw_type d;
            blit_type e;
            d = pending_draws.pop_front();
            e = clip_blit(d);
            expected_blits.push_back(e);
            if (e.dw == 16'd1 && e.dh == 16'd1) fallbacks <= fallbacks + 1;
            accepted <= accepted + 1;
         end
         if ((req_valid && !req_stall) || !req_valid) begin
            if (pending_draws.size() > 0 && !($urandom_range(99) < send_idle)) begin
               req_valid <= 1;
               req_dst_x <= pending_draws[0].dx; req_dst_y <= pending_draws[0].dy;
               req_dst_w <= pending_draws[0].dw; req_dst_h <= pending_draws[0].dh;
               req_src_x <= pending_draws[0].sx; req_src_y <= pending_draws[0].sy;
               req_src_w <= pending_draws[0].sw; req_src_h <= pending_draws[0].sh;
            end else begin
               req_valid <= 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            blit_type a, e;
            a = '{rsp_out_dst_x, rsp_out_dst_y, rsp_out_dst_w, rsp_out_dst_h,
                  rsp_out_src_x, rsp_out_src_y, rsp_out_src_w, rsp_out_src_h};
            received <= received + 1;
            if (expected_blits.size() == 0) begin
               $display("%0t unexpected word %h", $time, a);
               errors <= errors + 1;
            end else begin
               e = expected_blits.pop_front();
               if (a !== e) begin
                  $display("%0t mismatch expected %h actual %h", $time, e, a);
                  errors <= errors + 1;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle);
      end
   end

   task automatic set_clip(logic [15:0] x0, logic [15:0] y0, logic [14:0] wx, logic [14:0] hy);
      logic [15:0] v[4];
      v = '{x0, y0, {1'b0, wx}, {1'b0, hy}};
      for (int i = 0; i < 4; i++) begin
         @(posedge clock);
         csr_write_enable <= 1;
         csr_index <= scr_pkg::csr_index_type'(i);
         csr_wdata <= v[i];
      end
      @(posedge clock);
      csr_write_enable <= 0;
      clip_x0 = x0; clip_y0 = y0; clip_wx = wx; clip_hy = hy;
   endtask

   task automatic drain();
      while (pending_draws.size() != 0 || req_valid || expected_blits.size() != 0)
         @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   function automatic draw_type rand_draw(bit neat);
      draw_type d;
      d.dx = 16'($urandom);
      d.dy = 16'($urandom);
      d.dw = 16'($urandom);
      d.dh = 16'($urandom);
      d.sx = 15'($urandom);
      d.sy = 15'($urandom);
      d.sw = 15'($urandom);
      d.sh = 15'($urandom);
      if (neat) begin
         d.dx = 16'(clip_x0 + $signed(16'($urandom_range(600))) - 300);
         d.dy = 16'(clip_y0 + $signed(16'($urandom_range(600))) - 300);
         d.dw = 16'($urandom_range(1, 700));
         d.dh = 16'($urandom_range(1, 700));
         if ($urandom_range(3) == 0) d.sw = 15'($urandom_range(64));
      end
      return d;
   endfunction

   initial begin
      draw_type d;
      repeat (6) @(posedge clock);
      reset <= 0;
      d = '{16'sd0, 16'sd0, 16'sd10, 16'sd10, 15'd0, 15'd0, 15'd5, 15'd5};
      pending_draws.push_back(d);
      drain();
      set_clip(16'd10, 16'd20, 15'd100, 15'd50);
      pending_draws.push_back('{16'sd0, 16'sd0, 16'sd200, 16'sd200, 15'd7, 15'd9, 15'd400, 15'd30});
      pending_draws.push_back('{16'sd15, 16'sd25, 16'sd20, 16'sd20, 15'd1, 15'd2, 15'd3, 15'd4});
      pending_draws.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd5, 15'd1, 15'd1, 15'd1, 15'd1});
      pending_draws.push_back('{16'sd0, 16'sd0, 16'sd5, -16'sd5, 15'd1, 15'd1, 15'd1, 15'd1});
      pending_draws.push_back('{16'sd500, 16'sd500, 16'sd5, 16'sd5, 15'd3, 15'd3, 15'd3, 15'd3});
      pending_draws.push_back('{16'sd5, 16'sd15, 16'sd50, 16'sd50, 15'd0, 15'd0, 15'd0, 15'd0});
      pending_draws.push_back('{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff});
      pending_draws.push_back('{16'sh8000, 16'sh8000, 16'h7fff, 16'h7fff,
                                15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff});
      pending_draws.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                                15'd0, 15'd0, 15'd0, 15'd0});
      drain();
      set_clip(16'h8000, 16'h8000, 15'h7fff, 15'h7fff);
      pending_draws.push_back('{16'sh8000, 16'sh8000, 16'h7fff, 16'h7fff,
                                15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff});
      pending_draws.push_back('{16'sh8100, 16'sh8100, 16'sd3000, 16'sd3, 15'd100, 15'd9, 15'h7fff, 15'd1});
      drain();
      set_clip(16'h7fff, 16'h7fff, 15'h7fff, 15'h7fff);
      pending_draws.push_back('{16'h7f00, 16'h7f00, 16'h7fff, 16'h7fff, 15'd5, 15'd5, 15'd300, 15'h7fff});
      drain();
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 8 : (ph == 1) ? 82 : 0;
         recv_idle = (ph == 0) ? 82 : (ph == 1) ? 8 : 0;
         for (int s = 0; s < 3; s++) begin
            set_clip(16'($urandom), 16'($urandom),
                     (s == 0) ? 15'($urandom_range(2)) : 15'($urandom),
                     (s == 2) ? 15'h7fff : 15'($urandom_range(900)));
            for (int i = 0; i < 145; i++)
               pending_draws.push_back(rand_draw($urandom_range(9) < 8));
            drain();
         end
      end
      $display("tb: %0d draws accepted, %0d results checked, %0d clipped away or empty",
               accepted, received, fallbacks);
      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule
